### design/id_allocator_with_recycle_stack_defines.svh
// assertion macros shared by the allocator files
`ifndef ID_ALLOCATOR_WITH_RECYCLE_STACK_DEFINES_SVH
`define ID_ALLOCATOR_WITH_RECYCLE_STACK_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define IALLOC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IALLOC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IALLOC_ASSERT(label, clk, rst, prop, msg)
`define IALLOC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### design/ialloc_pkg.sv
package ialloc_pkg;

  localparam int ID_W = 32;
  localparam int STORE_DEPTH_DEF = 256;
  localparam logic [ID_W-1:0] ID_ALL_ONES = '1;

  typedef enum logic {
    CMD_ASSIGN  = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_EXHAUSTED   = 2'd1,
    ST_BELOW_FIRST = 2'd2,
    ST_STORE_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t            command;
    logic [ID_W-1:0] release_id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] assigned_id;
    status_t         status;
    logic            available;
  } rsp_t;

  typedef logic [ID_W-1:0] cfg_t;

  // stack control from the allocator core
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stk_ctrl_t;

endpackage

### design/ialloc_chan_if.sv
interface ialloc_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/id_allocator_with_recycle_stack.sv
// Identifier allocator with a LIFO recycle stack. Each request transfer on req is either an
// assign, which returns the most recently released identifier or else the next counter value,
// or a release, which steps the counter back when the identifier is the last one issued and
// otherwise pushes it onto the stack; one below the base or one meeting a full stack is refused.
// One result is given per request, in order. A request is held in the input register and is
// resolved into the result register once that register is free or its result is taken.
// One request is accepted every cycle while rsp is taken; a result held back on rsp, with a
// request waiting behind it in the input register, drops req.ready until that result goes. The
// rate is held by keeping the stack top and the entry below it in registers, with the ram read
// one entry ahead. Writing the base identifier on cfg reloads the counter and empties the stack
// in the same cycle; there is no clearing pass after reset.
`include "id_allocator_with_recycle_stack_defines.svh"

module id_allocator_with_recycle_stack #(
  parameter int STORE_DEPTH = ialloc_pkg::STORE_DEPTH_DEF,
  localparam int CW = $clog2(STORE_DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst,
  ialloc_chan_if.sink   req,
  ialloc_chan_if.source rsp,
  ialloc_chan_if.sink   cfg
);

  ialloc_pkg::req_t            req_q;
  logic                        req_q_valid;
  ialloc_pkg::rsp_t            rsp_q;
  logic                        rsp_q_valid;
  logic [ialloc_pkg::ID_W-1:0] base_id;
  logic [ialloc_pkg::ID_W-1:0] ctr;
  logic                        exh;
  logic [ialloc_pkg::ID_W-1:0] ctr_next;
  logic                        exh_next;
  logic                        advance;
  logic                        cfg_xfer;
  logic                        push_c;
  logic                        pop_c;
  logic [CW-1:0]               count;
  logic [CW-1:0]               count_after;
  logic [ialloc_pkg::ID_W-1:0] top_data;
  ialloc_pkg::stk_ctrl_t       stk_ctrl;
  ialloc_pkg::rsp_t            res;

  assign advance   = req_q_valid && (!rsp_q_valid || rsp.ready);
  assign req.ready = !req_q_valid || advance;
  assign cfg.ready = 1'b1;
  assign cfg_xfer  = cfg.valid && cfg.ready;
  assign rsp.valid = rsp_q_valid;
  assign rsp.data  = rsp_q;

  always_comb begin
    ctr_next        = ctr;
    exh_next        = exh;
    push_c          = 1'b0;
    pop_c           = 1'b0;
    res.assigned_id = '0;
    res.status      = ialloc_pkg::ST_OK;
    if (req_q.command == ialloc_pkg::CMD_ASSIGN) begin
      if (count != '0) begin
        pop_c           = 1'b1;
        res.assigned_id = top_data;
      end else if (exh) begin
        res.assigned_id = ialloc_pkg::ID_ALL_ONES;
        res.status      = ialloc_pkg::ST_EXHAUSTED;
      end else begin
        res.assigned_id = ctr;
        if (ctr == ialloc_pkg::ID_ALL_ONES) begin
          exh_next = 1'b1;
        end else begin
          ctr_next = ctr + ialloc_pkg::ID_W'(1);
        end
      end
    end else begin
      if (req_q.release_id < base_id) begin
        res.status = ialloc_pkg::ST_BELOW_FIRST;
      end else if (!exh &&
                   (({1'b0, req_q.release_id} + (ialloc_pkg::ID_W+1)'(1)) == {1'b0, ctr})) begin
        // last issued identifier comes back: step the counter back
        ctr_next = ctr - ialloc_pkg::ID_W'(1);
      end else if (count >= CW'(STORE_DEPTH)) begin
        res.status = ialloc_pkg::ST_STORE_FULL;
      end else begin
        push_c = 1'b1;
      end
    end
    count_after = count + CW'(push_c) - CW'(pop_c);
    res.available = (count_after != '0) || !exh_next;
  end

  assign stk_ctrl.push  = advance && push_c;
  assign stk_ctrl.pop   = advance && pop_c;
  assign stk_ctrl.clear = cfg_xfer;

  ialloc_stack #(
    .DEPTH (STORE_DEPTH)
  ) u_stack (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (stk_ctrl),
    .push_data (req_q.release_id),
    .top_data  (top_data),
    .count     (count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
      rsp_q_valid <= 1'b0;
      base_id     <= '0;
      ctr         <= '0;
      exh         <= 1'b0;
    end else begin
      if (req.ready) begin
        req_q_valid <= req.valid;
      end
      if (advance) begin
        rsp_q_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_q_valid <= 1'b0;
      end
      if (cfg_xfer) begin
        base_id <= cfg.data;
        ctr     <= cfg.data;
        exh     <= 1'b0;
      end else if (advance) begin
        ctr <= ctr_next;
        exh <= exh_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_q <= req.data;
    end
    if (advance) begin
      rsp_q <= res;
    end
  end

  `IALLOC_ASSERT(a_exh_at_top, clk, rst, exh |-> (ctr == ialloc_pkg::ID_ALL_ONES),
                 "exhausted with counter below all-ones")
  `IALLOC_ASSERT(a_ctr_floor, clk, rst, ctr >= base_id, "counter below first identifier")
  `IALLOC_ASSERT(a_exh_result, clk, rst,
                 (rsp_q_valid && (rsp_q.status == ialloc_pkg::ST_EXHAUSTED)) |->
                 (rsp_q.assigned_id == ialloc_pkg::ID_ALL_ONES && !rsp_q.available),
                 "exhausted result malformed")

endmodule

### design/ialloc_ram.sv
module ialloc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/ialloc_stack.sv
`include "id_allocator_with_recycle_stack_defines.svh"

module ialloc_stack #(
  parameter int DEPTH = ialloc_pkg::STORE_DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ialloc_pkg::stk_ctrl_t       ctrl,
  input  logic [ialloc_pkg::ID_W-1:0] push_data,
  output logic [ialloc_pkg::ID_W-1:0] top_data,
  output logic [CW-1:0]               count
);

  // top entry and the one below it live in registers, the rest in the ram
  logic [ialloc_pkg::ID_W-1:0] top;
  logic [ialloc_pkg::ID_W-1:0] second;
  logic [ialloc_pkg::ID_W-1:0] second_cur;
  logic                        second_from_ram;
  logic [ialloc_pkg::ID_W-1:0] ram_rdata;
  logic [CW-1:0]               waddr_full;
  logic [CW-1:0]               raddr_full;
  logic                        ram_we;

  assign second_cur = second_from_ram ? ram_rdata : second;
  assign waddr_full = count - CW'(1);
  // prefetch the entry that becomes second after a pop
  assign raddr_full = count - CW'(3);
  assign ram_we     = ctrl.push && (count != '0);
  assign top_data   = top;

  ialloc_ram #(
    .WIDTH (ialloc_pkg::ID_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr_full[AW-1:0]),
    .wdata (top),
    .raddr (raddr_full[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count           <= '0;
      second_from_ram <= 1'b0;
    end else if (ctrl.clear) begin
      count           <= '0;
      second_from_ram <= 1'b0;
    end else if (ctrl.push) begin
      count           <= count + CW'(1);
      second_from_ram <= 1'b0;
    end else if (ctrl.pop) begin
      count           <= count - CW'(1);
      second_from_ram <= 1'b1;
    end else begin
      second_from_ram <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      top    <= push_data;
      second <= top;
    end else if (ctrl.pop) begin
      top    <= second_cur;
    end else begin
      second <= second_cur;
    end
  end

  `IALLOC_ASSERT(a_count_bound, clk, rst, count <= CW'(DEPTH), "stack count over depth")
  `IALLOC_ASSERT(a_no_push_full, clk, rst, ctrl.push |-> (count < CW'(DEPTH)), "push on full stack")
  `IALLOC_ASSERT(a_no_pop_empty, clk, rst, ctrl.pop |-> (count != '0), "pop on empty stack")
  `IALLOC_ASSERT(a_push_top, clk, rst, (ctrl.push && !ctrl.clear) |=> (top == $past(push_data)),
                 "pushed value not on top")

endmodule

### bench/id_grant_checker.sv
`timescale 1ns / 100ps

module id_grant_checker #(
  parameter int STORE_DEPTH = ialloc_pkg::STORE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_ready,
  input  ialloc_pkg::req_t req_data,
  input  logic             rsp_valid,
  input  logic             rsp_ready,
  input  ialloc_pkg::rsp_t rsp_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  ialloc_pkg::cfg_t cfg_data,
  output int               mismatch_count,
  output int               grants_outstanding
);

  ialloc_pkg::cfg_t            base_id;
  logic [ialloc_pkg::ID_W-1:0] next_id;
  logic                        id_exhausted;
  logic [ialloc_pkg::ID_W-1:0] recycle [STORE_DEPTH];
  int                          recycle_count;
  ialloc_pkg::rsp_t            expected_grants[$];
  int                          errors = 0;

  // a base id write restarts the counter and empties the stack
  function automatic void load_base(input ialloc_pkg::cfg_t value);
    base_id = value;
    next_id = value;
    id_exhausted = 1'b0;
    recycle_count = 0;
  endfunction

  function automatic ialloc_pkg::rsp_t resolve_request(input ialloc_pkg::req_t r);
    ialloc_pkg::rsp_t res;
    res.assigned_id = '0;
    res.status = ialloc_pkg::ST_OK;
    if (r.command == ialloc_pkg::CMD_ASSIGN) begin
      if (recycle_count > 0) begin
        recycle_count--;
        res.assigned_id = recycle[recycle_count];
      end else if (id_exhausted) begin
        res.assigned_id = ialloc_pkg::ID_ALL_ONES;
        res.status = ialloc_pkg::ST_EXHAUSTED;
      end else begin
        res.assigned_id = next_id;
        if (next_id == ialloc_pkg::ID_ALL_ONES) id_exhausted = 1'b1;
        else next_id = next_id + ialloc_pkg::ID_W'(1);
      end
    end else begin
      if (r.release_id < base_id) begin
        res.status = ialloc_pkg::ST_BELOW_FIRST;
      // step back compare in 33 bits so all-ones never matches a zero counter
      end else if (!id_exhausted && ({1'b0, r.release_id} + 33'd1) == {1'b0, next_id}) begin
        next_id = next_id - ialloc_pkg::ID_W'(1);
      end else if (recycle_count >= STORE_DEPTH) begin
        res.status = ialloc_pkg::ST_STORE_FULL;
      end else begin
        recycle[recycle_count] = r.release_id;
        recycle_count++;
      end
    end
    res.available = (recycle_count > 0) || !id_exhausted;
    return res;
  endfunction

  always @(posedge clk) begin
    ialloc_pkg::rsp_t want;
    if (rst) begin
      load_base('0);
      expected_grants.delete();
    end else begin
      if (cfg_valid && cfg_ready) load_base(cfg_data);
      if (req_valid && req_ready) expected_grants.push_back(resolve_request(req_data));
      if (rsp_valid && rsp_ready) begin
        if (expected_grants.size() == 0) begin
          errors++;
          if (errors < 100)
            $display("%0t: unexpected result transfer, expected none got %h", $time, rsp_data);
        end else begin
          want = expected_grants.pop_front();
          if (rsp_data.assigned_id !== want.assigned_id) begin
            errors++;
            if (errors < 100)
              $display("%0t: assigned_id expected %h got %h", $time, want.assigned_id,
                       rsp_data.assigned_id);
          end
          if (rsp_data.status !== want.status) begin
            errors++;
            if (errors < 100)
              $display("%0t: status expected %0d got %0d", $time, want.status,
                       rsp_data.status);
          end
          if (rsp_data.available !== want.available) begin
            errors++;
            if (errors < 100)
              $display("%0t: available expected %b got %b", $time, want.available,
                       rsp_data.available);
          end
        end
      end
    end
    grants_outstanding <= expected_grants.size();
    mismatch_count <= errors;
  end

endmodule

### bench/tb_id_allocator_with_recycle_stack.sv
`timescale 1ns / 100ps

module tb_id_allocator_with_recycle_stack;

  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst;
  bit   req_quiet = 1'b0;
  bit   rsp_quiet = 1'b0;
  int   cycle_count = 0;
  int   mismatch_count;
  int   grants_outstanding;

  ialloc_chan_if #(.payload_t(ialloc_pkg::req_t)) req_if ();
  ialloc_chan_if #(.payload_t(ialloc_pkg::rsp_t)) rsp_if ();
  ialloc_chan_if #(.payload_t(ialloc_pkg::cfg_t)) cfg_if ();

  id_allocator_with_recycle_stack DUT (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .cfg(cfg_if)
  );

  id_grant_checker checker_i (
    .clk(clk),
    .rst(rst),
    .req_valid(req_if.valid),
    .req_ready(req_if.ready),
    .req_data(req_if.data),
    .rsp_valid(rsp_if.valid),
    .rsp_ready(rsp_if.ready),
    .rsp_data(rsp_if.data),
    .cfg_valid(cfg_if.valid),
    .cfg_ready(cfg_if.ready),
    .cfg_data(cfg_if.data),
    .mismatch_count(mismatch_count),
    .grants_outstanding(grants_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stall before each transfer
  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = rsp_quiet ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_if.valid) @(posedge clk);
    end
  end

  task automatic send_item(input ialloc_pkg::cmd_t command,
                           input logic [ialloc_pkg::ID_W-1:0] release_id);
    ialloc_pkg::req_t item;
    int gap;
    item.command = command;
    item.release_id = release_id;
    gap = req_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data <= item;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  // drain: stop sending and let every outstanding result transfer
  task automatic wait_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (grants_outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_base_id(input ialloc_pkg::cfg_t value);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_items(input ialloc_pkg::cfg_t base, input int count,
                           input int release_pct);
    logic [ialloc_pkg::ID_W-1:0] rid;
    int pick;
    for (int n = 0; n < count; n++) begin
      if (n % 48 == 0) begin
        req_quiet = ($urandom_range(0, 3) == 0);
        rsp_quiet = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 9);
      // mostly ids near the counter so step back and reuse happen often
      if (pick < 5) rid = base + $urandom_range(0, 24);
      else if (pick < 7 || base == '0) rid = $urandom;
      else if (pick < 9) rid = $urandom_range(0, base - 1);
      else rid = base;
      if ($urandom_range(1, 100) <= release_pct) send_item(ialloc_pkg::CMD_RELEASE, rid);
      else send_item(ialloc_pkg::CMD_ASSIGN, rid);
    end
  endtask

  task automatic run_phase(input ialloc_pkg::cfg_t base, input int count,
                           input int release_pct);
    wait_results();
    write_base_id(base);
    run_items(base, count, release_pct);
  endtask

  initial begin
    ialloc_pkg::cfg_t base;
    rst <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // first id zero from reset; all-ones release must not step back a zero counter
    send_item(ialloc_pkg::CMD_RELEASE, 32'hFFFF_FFFF);
    send_item(ialloc_pkg::CMD_ASSIGN, 32'h0);
    send_item(ialloc_pkg::CMD_ASSIGN, 32'h0);
    send_item(ialloc_pkg::CMD_ASSIGN, 32'h0);
    send_item(ialloc_pkg::CMD_RELEASE, 32'h1);
    send_item(ialloc_pkg::CMD_RELEASE, 32'h0);
    send_item(ialloc_pkg::CMD_RELEASE, 32'h8);
    send_item(ialloc_pkg::CMD_ASSIGN, 32'h0);
    send_item(ialloc_pkg::CMD_ASSIGN, 32'hFFFF_FFFF);

    // counter runs into the top of the id space
    wait_results();
    write_base_id(32'hFFFF_FFFD);
    send_item(ialloc_pkg::CMD_RELEASE, 32'h0);
    send_item(ialloc_pkg::CMD_RELEASE, 32'hFFFF_FFFC);
    send_item(ialloc_pkg::CMD_ASSIGN, 32'h0);
    send_item(ialloc_pkg::CMD_ASSIGN, 32'h0);
    send_item(ialloc_pkg::CMD_RELEASE, 32'hFFFF_FFFE);
    send_item(ialloc_pkg::CMD_ASSIGN, 32'h0);
    send_item(ialloc_pkg::CMD_ASSIGN, 32'h0);
    send_item(ialloc_pkg::CMD_ASSIGN, 32'h0);
    send_item(ialloc_pkg::CMD_RELEASE, 32'hFFFF_FFFF);
    send_item(ialloc_pkg::CMD_ASSIGN, 32'h0);
    send_item(ialloc_pkg::CMD_ASSIGN, 32'h0);

    wait_results();
    write_base_id(32'hFFFF_FFFF);
    send_item(ialloc_pkg::CMD_ASSIGN, 32'h0);
    send_item(ialloc_pkg::CMD_RELEASE, 32'hFFFF_FFFF);
    send_item(ialloc_pkg::CMD_RELEASE, 32'hFFFF_FFFE);
    send_item(ialloc_pkg::CMD_ASSIGN, 32'h0);
    send_item(ialloc_pkg::CMD_ASSIGN, 32'h0);

    // fill the stack past full, then pop it back down
    run_phase('0, 280, 100);
    run_items('0, 40, 20);

    base = $urandom;
    run_phase(base, 75, 50);
    wait_results();
    run_items(base, 75, 50);

    run_phase(32'hFFFF_FFF0, 120, 40);
    run_phase(32'hFFFF_FFFF, 30, 50);
    run_phase('0, 120, 55);
    run_phase($urandom_range(1, 1000), 80, 50);

    wait_results();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
